### rtl/retriggerable_led_fade_controller_macros.svh
// Assertion macros for the retriggerable LED fade controller
`ifndef RETRIGGERABLE_LED_FADE_CONTROLLER_MACROS_SVH
`define RETRIGGERABLE_LED_FADE_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define LFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfc same-cycle check failed");
`define LFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfc next-cycle check failed");
`else
`define LFC_ASSERT_SAME(label, ante, cons)
`define LFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/lfc_pkg.sv
// Shared types, constants and ramp ROM for the LED fade controller
package lfc_pkg;

  localparam int RAMP_ENTRIES_DEF = 81;
  localparam int HOLD_MAX_DEF     = 50;
  localparam int ROM_SIZE         = 81;
  localparam int POT_W            = 10;
  localparam int ADC_FULL         = 1023;
  localparam int ADDR_W           = 4;
  localparam int DATA_W           = 32;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_PULSE_A    = 3'd1;
  localparam logic [2:0] PH_FADE_IN    = 3'd2;
  localparam logic [2:0] PH_PULSE_B    = 3'd3;
  localparam logic [2:0] PH_HOLD_CHECK = 3'd4;
  localparam logic [2:0] PH_HOLD       = 3'd5;
  localparam logic [2:0] PH_FADE_OUT   = 3'd6;

  localparam logic [1:0] REG_PULSE    = 2'd0;
  localparam logic [1:0] REG_FADE_IN  = 2'd1;
  localparam logic [1:0] REG_FADE_OUT = 2'd2;
  localparam logic [1:0] REG_HOLD     = 2'd3;

  localparam logic [7:0] PULSE_RST    = 8'd25;
  localparam logic [7:0] FADE_IN_RST  = 8'd1;
  localparam logic [7:0] FADE_OUT_RST = 8'd2;
  localparam logic [7:0] HOLD_RST     = 8'd25;
  localparam logic [7:0] LEVEL_FULL   = 8'd255;

  typedef struct packed {
    logic [7:0] pulse_ticks;
    logic [7:0] fade_in_step_ticks;
    logic [7:0] fade_out_step_ticks;
    logic [7:0] hold_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] led_level;
    logic       trigger;
    logic       active;
  } res_t;

  localparam logic [7:0] RAMP_ROM [0:ROM_SIZE-1] = '{
    8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,
    8'd8,   8'd8,   8'd9,   8'd9,   8'd10,  8'd11,  8'd11,  8'd12,  8'd13,  8'd14,
    8'd14,  8'd15,  8'd16,  8'd17,  8'd18,  8'd20,  8'd21,  8'd22,  8'd23,  8'd25,
    8'd26,  8'd28,  8'd30,  8'd31,  8'd33,  8'd35,  8'd37,  8'd39,  8'd42,  8'd44,
    8'd47,  8'd50,  8'd53,  8'd56,  8'd59,  8'd62,  8'd66,  8'd70,  8'd74,  8'd78,
    8'd83,  8'd87,  8'd93,  8'd98,  8'd104, 8'd110, 8'd116, 8'd123, 8'd130, 8'd137,
    8'd145, 8'd153, 8'd162, 8'd172, 8'd181, 8'd192, 8'd203, 8'd214, 8'd227, 8'd240,
    8'd254
  };

  function automatic logic [7:0] ramp_at(input logic [6:0] idx);
    logic [7:0] val;
    if (idx < 7'(ROM_SIZE)) begin
      val = RAMP_ROM[idx];
    end else begin
      val = RAMP_ROM[ROM_SIZE-1];
    end
    return val;
  endfunction

endpackage

### rtl/lfc_cfg.sv
// APB register file for the fade controller timing registers
module lfc_cfg import lfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic [7:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_ticks         <= PULSE_RST;
      cfg_r.fade_in_step_ticks  <= FADE_IN_RST;
      cfg_r.fade_out_step_ticks <= FADE_OUT_RST;
      cfg_r.hold_period_ticks   <= HOLD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PULSE:    cfg_r.pulse_ticks         <= pwdata[7:0];
        REG_FADE_IN:  cfg_r.fade_in_step_ticks  <= pwdata[7:0];
        REG_FADE_OUT: cfg_r.fade_out_step_ticks <= pwdata[7:0];
        REG_HOLD:     cfg_r.hold_period_ticks   <= pwdata[7:0];
        default:      cfg_r.pulse_ticks         <= cfg_r.pulse_ticks;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PULSE:    rd_val = cfg_r.pulse_ticks;
      REG_FADE_IN:  rd_val = cfg_r.fade_in_step_ticks;
      REG_FADE_OUT: rd_val = cfg_r.fade_out_step_ticks;
      REG_HOLD:     rd_val = cfg_r.hold_period_ticks;
      default:      rd_val = 8'd0;
    endcase
  end

  assign prdata = {{(DATA_W-8){1'b0}}, rd_val};
  assign cfg    = cfg_r;

endmodule

### rtl/lfc_hold.sv
// Hold count from the pot level: pot * HOLD_MAX / 1023
module lfc_hold import lfc_pkg::*; #(
  parameter int HOLD_MAX = HOLD_MAX_DEF,
  parameter int HW       = $clog2(HOLD_MAX + 1)
) (
  input  logic [POT_W-1:0] pot_level,
  output logic [HW-1:0]    hold_count
);

  localparam int PW = POT_W + HW;

  logic [PW-1:0]    prod;
  logic [HW-1:0]    quot_lo;
  logic [POT_W:0]   rem;

  assign prod    = PW'(pot_level) * PW'(HOLD_MAX);
  assign quot_lo = prod[PW-1:POT_W];
  assign rem     = {1'b0, prod[POT_W-1:0]} + (POT_W+1)'(quot_lo);
  assign hold_count = quot_lo + HW'(rem >= (POT_W+1)'(ADC_FULL));

endmodule

### rtl/lfc_core.sv
// Fade sequencer state and per-tick next-state and result logic
module lfc_core import lfc_pkg::*; #(
  parameter int RAMP_ENTRIES = RAMP_ENTRIES_DEF,
  parameter int HOLD_MAX     = HOLD_MAX_DEF,
  parameter int HW           = $clog2(HOLD_MAX + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          button,
  input  logic [HW-1:0] hold_load,
  input  cfg_t          cfg,
  output res_t          res
);

  localparam int IW = (RAMP_ENTRIES > 1) ? $clog2(RAMP_ENTRIES) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(RAMP_ENTRIES - 1);
  localparam logic [IW-1:0] IDX_ONE  = IW'(1);

  logic [2:0]    phase_r, phase_nxt;
  logic [7:0]    tick_r, tick_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [HW-1:0] hold_r, hold_nxt;
  logic [7:0]    level_r, level_nxt;

  logic [2:0]    ph;
  logic [7:0]    tc;
  logic [HW-1:0] hl;
  logic [HW-1:0] hl_dec;
  logic [7:0]    tick_inc;
  logic [7:0]    dur;
  logic          done;
  logic [7:0]    ramp_val;

  always_comb begin
    ph = phase_r;
    tc = tick_r;
    hl = hold_r;
    if (phase_r == PH_IDLE && button) begin
      hl = hold_load;
      ph = PH_PULSE_A;
      tc = 8'd0;
    end else if (phase_r == PH_HOLD_CHECK) begin
      if (button) begin
        hl = hold_load;
        ph = PH_PULSE_B;
      end else begin
        ph = PH_HOLD;
      end
      tc = 8'd0;
    end
  end

  always_comb begin
    case (ph)
      PH_FADE_IN:  dur = cfg.fade_in_step_ticks;
      PH_FADE_OUT: dur = cfg.fade_out_step_ticks;
      PH_HOLD:     dur = cfg.hold_period_ticks;
      default:     dur = cfg.pulse_ticks;
    endcase
  end

  assign tick_inc = tc + 8'd1;
  assign done     = tick_inc >= dur;
  assign ramp_val = ramp_at(7'(idx_r));
  assign hl_dec   = (hl != '0) ? hl - HW'(1) : hl;

  always_comb begin
    phase_nxt     = ph;
    tick_nxt      = done ? 8'd0 : tick_inc;
    idx_nxt       = idx_r;
    hold_nxt      = hl;
    level_nxt     = level_r;
    res.led_level = level_r;
    res.trigger   = 1'b0;
    res.active    = 1'b1;
    unique case (ph)
      PH_PULSE_A: begin
        res.trigger = 1'b1;
        if (done) begin
          phase_nxt = PH_FADE_IN;
          idx_nxt   = '0;
        end
      end
      PH_FADE_IN: begin
        level_nxt     = ramp_val;
        res.led_level = ramp_val;
        if (done) begin
          if (idx_r == IDX_LAST) begin
            phase_nxt = PH_PULSE_B;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      PH_PULSE_B: begin
        res.trigger = 1'b1;
        if (done) begin
          if (hl != '0) begin
            phase_nxt = PH_HOLD;
          end else begin
            phase_nxt = PH_FADE_OUT;
            idx_nxt   = IDX_LAST;
          end
        end
      end
      PH_HOLD: begin
        level_nxt     = LEVEL_FULL;
        res.led_level = LEVEL_FULL;
        if (done) begin
          hold_nxt = hl_dec;
          if (hl_dec == '0) begin
            phase_nxt = PH_FADE_OUT;
            idx_nxt   = IDX_LAST;
          end else begin
            phase_nxt = PH_HOLD_CHECK;
          end
        end
      end
      PH_FADE_OUT: begin
        level_nxt     = ramp_val;
        res.led_level = ramp_val;
        if (done) begin
          if (idx_r <= IDX_ONE) begin
            phase_nxt = PH_IDLE;
            level_nxt = 8'd0;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r - IW'(1);
          end
        end
      end
      default: begin
        phase_nxt     = PH_IDLE;
        tick_nxt      = (ph == PH_IDLE) ? tc : 8'd0;
        level_nxt     = 8'd0;
        res.led_level = 8'd0;
        res.active    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 8'd0;
      idx_r   <= '0;
      hold_r  <= '0;
      level_r <= 8'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      idx_r   <= idx_nxt;
      hold_r  <= hold_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

### rtl/retriggerable_led_fade_controller.sv
// Top level: retriggerable LED fade controller with input and result registers
// Each input transfer passes through the input register and then the result register to out_valid.
// Throughput: one tick per cycle while out_stall is low; the sequencer state updates once per tick.
// The hold count division is done before the input register.
// Reset (synchronous, active low): idle, LED dark, registers at defaults.
`include "retriggerable_led_fade_controller_macros.svh"
module retriggerable_led_fade_controller import lfc_pkg::*; #(
  parameter int RAMP_ENTRIES = RAMP_ENTRIES_DEF,
  parameter int HOLD_MAX     = HOLD_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_button,
  input  logic [POT_W-1:0]  in_pot_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_led_level,
  output logic              out_trigger,
  output logic              out_active,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int HW = $clog2(HOLD_MAX + 1);

  cfg_t          cfg;
  res_t          res;
  res_t          out_r;
  logic          out_valid_r;
  logic          s1_valid_r;
  logic          s1_button_r;
  logic [HW-1:0] s1_hold_r;
  logic [HW-1:0] hold_count;
  logic          out_free;
  logic          in_take;
  logic          step_en;

  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  lfc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfc_hold #(
    .HOLD_MAX (HOLD_MAX),
    .HW       (HW)
  ) u_hold (
    .pot_level  (in_pot_level),
    .hold_count (hold_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_button_r <= in_button;
      s1_hold_r   <= hold_count;
    end
  end

  lfc_core #(
    .RAMP_ENTRIES (RAMP_ENTRIES),
    .HOLD_MAX     (HOLD_MAX),
    .HW           (HW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .button    (s1_button_r),
    .hold_load (s1_hold_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_level = out_r.led_level;
  assign out_trigger   = out_r.trigger;
  assign out_active    = out_r.active;

  `LFC_ASSERT_SAME(a_trig_active, out_valid && out_trigger, out_active)
  `LFC_ASSERT_SAME(a_idle_dark, out_valid && !out_active, out_led_level == 8'd0)
  `LFC_ASSERT_NEXT(a_step_result, step_en, out_valid_r)

endmodule

### sim/retriggerable_led_fade_controller_test.sv
// Self-checking testbench for the retriggerable LED fade controller
module retriggerable_led_fade_controller_test;
  import lfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAST_STEP       = 80;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int CYCLE_LIMIT     = 100000;

  localparam logic [7:0] LEVEL_STEPS [0:LAST_STEP] = '{
    8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,
    8'd8,   8'd8,   8'd9,   8'd9,   8'd10,  8'd11,  8'd11,  8'd12,  8'd13,  8'd14,
    8'd14,  8'd15,  8'd16,  8'd17,  8'd18,  8'd20,  8'd21,  8'd22,  8'd23,  8'd25,
    8'd26,  8'd28,  8'd30,  8'd31,  8'd33,  8'd35,  8'd37,  8'd39,  8'd42,  8'd44,
    8'd47,  8'd50,  8'd53,  8'd56,  8'd59,  8'd62,  8'd66,  8'd70,  8'd74,  8'd78,
    8'd83,  8'd87,  8'd93,  8'd98,  8'd104, 8'd110, 8'd116, 8'd123, 8'd130, 8'd137,
    8'd145, 8'd153, 8'd162, 8'd172, 8'd181, 8'd192, 8'd203, 8'd214, 8'd227, 8'd240,
    8'd254
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_button;
  logic [POT_W-1:0]  in_pot_level;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_led_level;
  logic              out_trigger;
  logic              out_active;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cfg_t       shadow_cfg = '{PULSE_RST, FADE_IN_RST, FADE_OUT_RST, HOLD_RST};
  logic [2:0] seq_phase  = PH_IDLE;
  logic [7:0] tick_cnt   = '0;
  logic [6:0] ramp_idx   = '0;
  logic [5:0] hold_left  = '0;
  logic [7:0] level_now  = '0;

  res_t led_expected [$];
  int   errors       = 0;
  int   cycle_count  = 0;
  bit   idling_on    = 1'b1;
  bit   hold_off_req = 1'b0;

  retriggerable_led_fade_controller dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] ramp_level(input logic [6:0] idx);
    return (idx <= 7'(LAST_STEP)) ? LEVEL_STEPS[idx] : LEVEL_STEPS[LAST_STEP];
  endfunction

  function automatic logic [5:0] hold_count(input logic [POT_W-1:0] pot);
    return 6'((32'(pot) * 32'd50) / 32'(ADC_FULL));
  endfunction

  function automatic logic count_tick(input logic [7:0] span);
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt >= span) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic advance_sequencer(input logic button, input logic [POT_W-1:0] pot);
    res_t       want;
    logic [2:0] shown_phase;
    want.trigger = 1'b0;
    if (seq_phase == PH_IDLE && button) begin
      hold_left = hold_count(pot);
      seq_phase = PH_PULSE_A;
      tick_cnt  = '0;
    end else if (seq_phase == PH_HOLD_CHECK) begin
      if (button) begin
        hold_left = hold_count(pot);
        seq_phase = PH_PULSE_B;
      end else begin
        seq_phase = PH_HOLD;
      end
      tick_cnt = '0;
    end
    if (seq_phase > PH_FADE_OUT) begin
      seq_phase = PH_IDLE;
      tick_cnt  = '0;
    end
    shown_phase = seq_phase;
    case (seq_phase)
      PH_PULSE_A: begin
        want.trigger   = 1'b1;
        want.led_level = level_now;
        if (count_tick(shadow_cfg.pulse_ticks)) begin
          seq_phase = PH_FADE_IN;
          ramp_idx  = '0;
        end
      end
      PH_FADE_IN: begin
        level_now      = ramp_level(ramp_idx);
        want.led_level = level_now;
        if (count_tick(shadow_cfg.fade_in_step_ticks)) begin
          if (ramp_idx >= 7'(LAST_STEP)) begin
            seq_phase = PH_PULSE_B;
          end else begin
            ramp_idx = ramp_idx + 7'd1;
          end
        end
      end
      PH_PULSE_B: begin
        want.trigger   = 1'b1;
        want.led_level = level_now;
        if (count_tick(shadow_cfg.pulse_ticks)) begin
          if (hold_left > 0) begin
            seq_phase = PH_HOLD;
          end else begin
            seq_phase = PH_FADE_OUT;
            ramp_idx  = 7'(LAST_STEP);
          end
        end
      end
      PH_HOLD: begin
        level_now      = LEVEL_FULL;
        want.led_level = level_now;
        if (count_tick(shadow_cfg.hold_period_ticks)) begin
          if (hold_left > 0) hold_left = hold_left - 6'd1;
          if (hold_left == 0) begin
            seq_phase = PH_FADE_OUT;
            ramp_idx  = 7'(LAST_STEP);
          end else begin
            seq_phase = PH_HOLD_CHECK;
          end
        end
      end
      PH_FADE_OUT: begin
        level_now      = ramp_level(ramp_idx);
        want.led_level = level_now;
        if (count_tick(shadow_cfg.fade_out_step_ticks)) begin
          if (ramp_idx <= 7'd1) begin
            seq_phase = PH_IDLE;
            level_now = '0;
            ramp_idx  = '0;
          end else begin
            ramp_idx = ramp_idx - 7'd1;
          end
        end
      end
      default: begin
        level_now      = '0;
        want.led_level = '0;
      end
    endcase
    want.active = (shown_phase != PH_IDLE);
    led_expected.push_back(want);
  endtask

  task automatic send_tick(input logic button, input logic [POT_W-1:0] pot);
    while (idling_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_button    <= button;
    in_pot_level <= pot;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_sequencer(button, pot);
    @(negedge clk);
  endtask

  function automatic logic [POT_W-1:0] pick_pot();
    case ($urandom_range(9))
      0, 1, 2:       return POT_W'($urandom_range(20));
      3, 4, 5, 6, 7: return POT_W'($urandom_range(130));
      default:       return POT_W'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_span();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
  endfunction

  task automatic run_ticks(input int count, input int press_pct);
    for (int i = 0; i < count; i++) begin
      send_tick($urandom_range(99) < press_pct, pick_pot());
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (led_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic access_reg(input logic [1:0] idx, input logic wr, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (!wr && prdata !== DATA_W'(val)) begin
      $display("%0t register %0d readback: expected %0h, actual %0h", $time, idx, val, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] pulse, input logic [7:0] fade_in,
                            input logic [7:0] fade_out, input logic [7:0] hold);
    quiesce();
    access_reg(REG_PULSE, 1'b1, pulse);
    access_reg(REG_FADE_IN, 1'b1, fade_in);
    access_reg(REG_FADE_OUT, 1'b1, fade_out);
    access_reg(REG_HOLD, 1'b1, hold);
    shadow_cfg = '{pulse, fade_in, fade_out, hold};
    access_reg(REG_PULSE, 1'b0, pulse);
    access_reg(REG_FADE_IN, 1'b0, fade_in);
    access_reg(REG_FADE_OUT, 1'b0, fade_out);
    access_reg(REG_HOLD, 1'b0, hold);
  endtask

  task automatic test_idle_and_press();
    send_tick(1'b0, '0);
    send_tick(1'b0, '1);
    send_tick(1'b0, 10'h2AA);
    send_tick(1'b1, '1);
    for (int i = 0; i < 18; i++) begin
      send_tick(i[0], i[1] ? 10'h155 : 10'h2AA);
    end
  endtask

  task automatic test_zero_durations();
    set_config('0, '0, '0, '0);
    while (seq_phase != PH_IDLE) send_tick(1'b0, pick_pot());
    send_tick(1'b1, 10'd20);
    while (seq_phase != PH_IDLE) send_tick(1'b0, pick_pot());
    send_tick(1'b1, 10'd21);
    run_ticks(120, 5);
  endtask

  task automatic test_min_durations();
    set_config(8'd1, 8'd1, 8'd1, 8'd1);
    run_ticks(150, 8);
  endtask

  task automatic test_max_durations();
    set_config('1, '1, '1, '1);
    run_ticks(100, 10);
  endtask

  task automatic test_random_configs();
    repeat (4) begin
      set_config(pick_span(), pick_span(), pick_span(), pick_span());
      run_ticks(60, 8);
    end
  endtask

  task automatic test_receiver_hold_off();
    set_config(8'd1, 8'd1, 8'd1, 8'd2);
    hold_off_req = 1'b1;
    run_ticks(120, 8);
  endtask

  task automatic test_back_to_back();
    set_config(PULSE_RST, FADE_IN_RST, FADE_OUT_RST, 8'd3);
    idling_on = 1'b0;
    run_ticks(120, 8);
    quiesce();
    idling_on = 1'b1;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= idling_on && ($urandom_range(99) < 18);
      end
    end
  end

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (led_expected.size() == 0) begin
        $display("%0t unexpected transfer: led_level %0d trigger %0b active %0b",
                 $time, out_led_level, out_trigger, out_active);
        errors++;
      end else begin
        want = led_expected.pop_front();
        compare_field("led_level", want.led_level, out_led_level);
        compare_field("trigger", 8'(want.trigger), 8'(out_trigger));
        compare_field("active", 8'(want.active), 8'(out_active));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_button    = 1'b0;
    in_pot_level = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_and_press();
    test_zero_durations();
    test_min_durations();
    test_max_durations();
    test_random_configs();
    test_receiver_hold_off();
    test_back_to_back();
    quiesce();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
